// ----- design/fe_pkg.sv -----
// Shared constants, types and codes of the fire effect frame engine.
package fe_pkg;

  localparam int unsigned FRAME_WIDTH  = 64;
  localparam int unsigned FRAME_HEIGHT = 48;
  localparam int unsigned MAX_HEAT     = 36;
  localparam int unsigned COOL_ROWS    = 7;

  localparam int unsigned FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(FRAME_SIZE);
  localparam int unsigned X_W        = $clog2(FRAME_WIDTH);
  localparam int unsigned Y_W        = $clog2(FRAME_HEIGHT);

  // Fixed field widths of the ports.
  localparam int unsigned HEAT_W     = 6;
  localparam int unsigned PIX_ADDR_W = 12;
  localparam int unsigned DELAY_W    = 8;
  localparam int unsigned SEED_W     = 32;

  localparam logic [HEAT_W-1:0]  MAX_HEAT_VAL      = HEAT_W'(MAX_HEAT);
  localparam logic [DELAY_W-1:0] DELAY_TARGET      = DELAY_W'(FRAME_HEIGHT / 4);
  localparam logic [DELAY_W-1:0] DELAY_STEP        = DELAY_W'(2);
  localparam logic [DELAY_W-1:0] START_DELAY_RESET = DELAY_W'(220);
  localparam logic [SEED_W-1:0]  SEED_RESET        = SEED_W'(1);
  localparam logic [SEED_W-1:0]  LFSR_TAPS         = 32'h8020_0003;

  // Address offsets used by the frame walks.
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((FRAME_HEIGHT - 1) * FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] COOL_BACK     = ADDR_W'(2 * FRAME_WIDTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(FRAME_SIZE - 1);
  localparam logic [ADDR_W:0]   DST_BIAS      = (ADDR_W + 1)'(FRAME_SIZE + 1 - FRAME_WIDTH);
  localparam logic [ADDR_W:0]   FRAME_SIZE_X  = (ADDR_W + 1)'(FRAME_SIZE);
  localparam logic [X_W-1:0]    LAST_COL      = X_W'(FRAME_WIDTH - 1);
  localparam logic [Y_W-1:0]    LAST_ROW      = Y_W'(FRAME_HEIGHT - 1);
  localparam logic [Y_W-1:0]    LAST_COOL_ROW = Y_W'(COOL_ROWS - 1);

  typedef enum logic [0:0] {
    CFG_START_DELAY = 1'b0,
    CFG_RANDOM_SEED = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ACT_ADVANCE = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  // Status of the core towards the top level.
  typedef struct packed {
    logic              ready;
    logic              valid;
    logic [HEAT_W-1:0] pixel_value;
    logic              restart_pending;
    logic              cooling_active;
  } core_res_t;

endpackage

// ----- design/fire_effect_frame_engine.sv -----
// Top level of the fire effect frame engine: ports, configuration and result register.
// The engine keeps a 64 x 48 frame of heat indices (0 to 36) in one single-port
// memory with a registered read, and takes one transaction at a time. A spreading
// advance walks columns then rows 1 to 47 with one read and one write per pixel;
// once the delay counter has reached height/4 the advance also cools the bottom 7
// rows and scans the whole frame for emptiness, one read a cycle. A restart advance
// rewrites the frame. After reset the frame is rewritten once, one entry a cycle,
// during which in_stall_o stays high; configuration writes are taken at any time
// with cfg_ready_o high, but are meant only while no transaction is in flight.
// Writing random_seed reloads the random source at once, a zero seed loading as
// one. A finished result waits in the output register, so the next transaction is
// accepted while the previous result is still stalled.
module fire_effect_frame_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [fe_pkg::PIX_ADDR_W-1:0] pixel_address_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fe_pkg::HEAT_W-1:0]     pixel_value_o,
  output logic                          restart_pending_o,
  output logic                          cooling_active_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [fe_pkg::SEED_W-1:0]     cfg_data_i
);
  import fe_pkg::*;

  core_res_t          res;
  logic               start;
  logic               res_take;
  logic               draw;
  logic [1:0]         rnd;
  logic               cfg_we;
  logic               seed_load;

  logic [DELAY_W-1:0] start_delay_q, start_delay_d;
  logic               out_valid_q, out_valid_d;
  logic [HEAT_W-1:0]  pixel_q, pixel_d;
  logic               restart_out_q, restart_out_d;
  logic               cooling_out_q, cooling_out_d;

  // Accept a transaction only while the sequencer idles.
  assign in_stall_o = ~res.ready;
  assign start      = in_valid_i & ~in_stall_o;

  // The result register frees up when it is empty or being taken.
  assign res_take = ~out_valid_q | ~out_stall_i;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    start_delay_d = start_delay_q;
    seed_load     = 1'b0;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_START_DELAY: start_delay_d = cfg_data_i[DELAY_W-1:0];
        CFG_RANDOM_SEED: seed_load     = 1'b1;
        default:         start_delay_d = start_delay_q;
      endcase
    end
  end

  // Load the result register when the core finishes, drop it once taken.
  always_comb begin
    out_valid_d   = out_valid_q;
    pixel_d       = pixel_q;
    restart_out_d = restart_out_q;
    cooling_out_d = cooling_out_q;
    if (res.valid && res_take) begin
      out_valid_d   = 1'b1;
      pixel_d       = res.pixel_value;
      restart_out_d = res.restart_pending;
      cooling_out_d = res.cooling_active;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= START_DELAY_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      start_delay_q <= start_delay_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q       <= pixel_d;
    restart_out_q <= restart_out_d;
    cooling_out_q <= cooling_out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign pixel_value_o     = pixel_q;
  assign restart_pending_o = restart_out_q;
  assign cooling_active_o  = cooling_out_q;

  fe_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (seed_load),
    .seed_i (cfg_data_i),
    .step_i (draw),
    .rnd_o  (rnd)
  );

  fe_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .action_i        (action_i),
    .pixel_address_i (pixel_address_i),
    .start_delay_i   (start_delay_q),
    .res_take_i      (res_take),
    .rnd_i           (rnd),
    .draw_o          (draw),
    .res_o           (res)
  );

endmodule

// ----- design/fe_lfsr.sv -----
// 32-bit Galois LFSR random source with seed load.
module fe_lfsr (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [fe_pkg::SEED_W-1:0] seed_i,
  input  logic                      step_i,
  output logic [1:0]                rnd_o
);
  import fe_pkg::*;

  logic [SEED_W-1:0] state_q, state_d, next_state;

  // One draw: shift right, fold in the taps when a one drops out.
  assign next_state = {1'b0, state_q[SEED_W-1:1]} ^ (state_q[0] ? LFSR_TAPS : '0);
  assign rnd_o      = next_state[1:0];

  always_comb begin
    state_d = state_q;
    if (load_i) begin
      state_d = (seed_i == '0) ? SEED_RESET : seed_i;
    end else if (step_i) begin
      state_d = next_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/fe_core.sv -----
// Frame memory and the sequencer that clears, spreads, cools and scans it.
module fe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          action_i,
  input  logic [fe_pkg::PIX_ADDR_W-1:0] pixel_address_i,
  input  logic [fe_pkg::DELAY_W-1:0]    start_delay_i,
  input  logic                          res_take_i,
  input  logic [1:0]                    rnd_i,
  output logic                          draw_o,
  output fe_pkg::core_res_t             res_o
);
  import fe_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_RD_WAIT  = 10'b00_0000_0100,
    S_SPR_RD   = 10'b00_0000_1000,
    S_SPR_WR   = 10'b00_0001_0000,
    S_COOL_RD  = 10'b00_0010_0000,
    S_COOL_WR  = 10'b00_0100_0000,
    S_SCAN     = 10'b00_1000_0000,
    S_SCAN_END = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [X_W-1:0]       x_q, x_d;
  logic [Y_W-1:0]       y_q, y_d;
  logic [DELAY_W-1:0]   delay_q, delay_d;
  logic                 restart_q, restart_d;
  logic                 clear_item_q, clear_item_d;
  logic                 nz_q, nz_d;
  logic                 scan_v_q, scan_v_d;
  logic [HEAT_W-1:0]    pix_q, pix_d;

  logic [HEAT_W-1:0]    mem [FRAME_SIZE];
  logic [HEAT_W-1:0]    rdata_q;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;
  logic [HEAT_W-1:0]    mem_wdata;

  logic [ADDR_W:0]      dst_sum;
  logic [ADDR_W-1:0]    dst_addr;
  logic                 in_range;
  logic                 rd_nz;

  // Spread target: src - width + 1 - r, wrapped into the frame.
  assign dst_sum  = {1'b0, cnt_q} + DST_BIAS - (ADDR_W + 1)'(rnd_i);
  assign dst_addr = (dst_sum >= FRAME_SIZE_X) ? ADDR_W'(dst_sum - FRAME_SIZE_X)
                                              : ADDR_W'(dst_sum);
  assign in_range = 32'(pixel_address_i) < 32'(FRAME_SIZE);
  assign rd_nz    = (rdata_q != '0);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    x_d          = x_q;
    y_d          = y_q;
    delay_d      = delay_q;
    restart_d    = restart_q;
    clear_item_d = clear_item_q;
    nz_d         = nz_q;
    scan_v_d     = scan_v_q;
    pix_d        = pix_q;
    mem_addr     = cnt_q;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    draw_o       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt_q >= LAST_ROW_BASE) ? MAX_HEAT_VAL : '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = clear_item_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          pix_d = '0;
          if (action_i == ACT_READ) begin
            mem_addr = ADDR_W'(pixel_address_i);
            state_d  = in_range ? S_RD_WAIT : S_DONE;
          end else if (restart_q) begin
            restart_d    = 1'b0;
            delay_d      = start_delay_i;
            clear_item_d = 1'b1;
            cnt_d        = '0;
            state_d      = S_CLEAR;
          end else begin
            cnt_d   = ROW_STEP;
            x_d     = '0;
            y_d     = Y_W'(1);
            state_d = S_SPR_RD;
          end
        end
      end
      S_RD_WAIT: begin
        pix_d   = rdata_q;
        state_d = S_DONE;
      end
      S_SPR_RD: begin
        state_d = S_SPR_WR;
      end
      S_SPR_WR: begin
        mem_we = 1'b1;
        if (rd_nz) begin
          draw_o    = 1'b1;
          mem_addr  = dst_addr;
          mem_wdata = rdata_q - HEAT_W'(rnd_i[0]);
        end else begin
          mem_addr  = cnt_q - ROW_STEP;
        end
        state_d = S_SPR_RD;
        if (y_q == LAST_ROW) begin
          x_d   = x_q + 1'b1;
          y_d   = Y_W'(1);
          cnt_d = ROW_STEP + ADDR_W'(x_q) + 1'b1;
          if (x_q == LAST_COL) begin
            if (delay_q != DELAY_TARGET) begin
              delay_d = delay_q - DELAY_STEP;
              state_d = S_DONE;
            end else begin
              cnt_d   = LAST_ROW_BASE;
              x_d     = '0;
              y_d     = '0;
              state_d = S_COOL_RD;
            end
          end
        end else begin
          y_d   = y_q + 1'b1;
          cnt_d = cnt_q + ROW_STEP;
        end
      end
      S_COOL_RD: begin
        state_d = S_COOL_WR;
      end
      S_COOL_WR: begin
        if (rd_nz) begin
          draw_o    = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = rdata_q - HEAT_W'(rnd_i[0]);
        end
        state_d = S_COOL_RD;
        if (x_q == LAST_COL) begin
          x_d   = '0;
          y_d   = y_q + 1'b1;
          cnt_d = cnt_q - COOL_BACK;
          if (y_q == LAST_COOL_ROW) begin
            cnt_d    = '0;
            nz_d     = 1'b0;
            scan_v_d = 1'b0;
            state_d  = S_SCAN;
          end
        end else begin
          x_d   = x_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCAN: begin
        // One read issued per cycle, its data checked in the cycle after.
        nz_d     = nz_q | (scan_v_q & rd_nz);
        scan_v_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        restart_d = ~(nz_q | rd_nz);
        state_d   = S_DONE;
      end
      S_DONE: begin
        clear_item_d = 1'b0;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      x_q          <= '0;
      y_q          <= '0;
      delay_q      <= START_DELAY_RESET;
      restart_q    <= 1'b0;
      clear_item_q <= 1'b0;
      nz_q         <= 1'b0;
      scan_v_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      x_q          <= x_d;
      y_q          <= y_d;
      delay_q      <= delay_d;
      restart_q    <= restart_d;
      clear_item_q <= clear_item_d;
      nz_q         <= nz_d;
      scan_v_q     <= scan_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  // Single-port frame memory, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  assign res_o.ready           = (state_q == S_IDLE);
  assign res_o.valid           = (state_q == S_DONE);
  assign res_o.pixel_value     = pix_q;
  assign res_o.restart_pending = restart_q;
  assign res_o.cooling_active  = (delay_q == DELAY_TARGET);

endmodule

// ----- dv/fire_effect_frame_engine_test.sv -----
// Self-checking testbench for the fire effect frame engine: shadow frame, directed and random traffic.
module fire_effect_frame_engine_test;
  import fe_pkg::*;

  // Longest correct quiet spell is a cooling advance behind a long result
  // hold-off; the reset clearing pass is shorter still.
  localparam int unsigned IDLE_LIMIT    = 50000;
  localparam int unsigned SETTLE_GAP    = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned BURN_CAP      = 260;
  localparam int unsigned SEED_INTERVAL = 30;
  localparam int unsigned ADDR_TOP      = (1 << PIX_ADDR_W) - 1;
  localparam int unsigned COOL_BASE     = (FRAME_HEIGHT - COOL_ROWS) * FRAME_WIDTH;
  // One delay step above the target, so a restart spreads once before cooling.
  localparam logic [DELAY_W-1:0] RESTART_DELAY = DELAY_TARGET + DELAY_STEP;

  typedef struct packed {
    logic [HEAT_W-1:0] pixel_value;
    logic              restart_pending;
    logic              cooling_active;
  } frame_status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [PIX_ADDR_W-1:0] pixel_address_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [HEAT_W-1:0]     pixel_value_o;
  logic                  restart_pending_o;
  logic                  cooling_active_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [SEED_W-1:0]     cfg_data_i;

  // Shadow copy of the engine state, advanced once per accepted transaction.
  logic [HEAT_W-1:0]  shadow_heat [FRAME_SIZE];
  logic [DELAY_W-1:0] shadow_delay;
  logic [DELAY_W-1:0] shadow_start_delay;
  logic               shadow_restart;
  logic [SEED_W-1:0]  shadow_lfsr;

  // Results still owed by the engine, oldest first.
  frame_status_t pending_status [$];

  int errors    = 0;
  int n_advance = 0;
  int n_read    = 0;
  int n_cooling = 0;
  int n_restart = 0;
  int sink_hold_request = 0;
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fire_effect_frame_engine uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .pixel_address_i   (pixel_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pixel_value_o     (pixel_value_o),
    .restart_pending_o (restart_pending_o),
    .cooling_active_o  (cooling_active_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Galois step of the random source; the new state is the draw.
  function automatic logic [SEED_W-1:0] lfsr_draw();
    shadow_lfsr = {1'b0, shadow_lfsr[SEED_W-1:1]} ^ (shadow_lfsr[0] ? LFSR_TAPS : '0);
    return shadow_lfsr;
  endfunction

  // Clear the frame, light the bottom row and reload the delay counter.
  function automatic void refill_frame();
    for (int i = 0; i < FRAME_SIZE; i++)
      shadow_heat[i] = (i >= LAST_ROW_BASE) ? MAX_HEAT_VAL : '0;
    shadow_delay = shadow_start_delay;
  endfunction

  // Apply one transaction to the shadow state and return the status it should produce.
  function automatic frame_status_t burn_step(action_e act, logic [PIX_ADDR_W-1:0] addr);
    frame_status_t     res;
    int                src;
    int                dst;
    int                pos;
    logic [SEED_W-1:0] r;
    logic [HEAT_W-1:0] p;
    bit                empty;
    res = '0;
    if (act == ACT_READ) begin
      // Reads beyond the frame return zero.
      if (addr < FRAME_SIZE) res.pixel_value = shadow_heat[addr];
    end else if (shadow_restart) begin
      refill_frame();
      shadow_restart = 1'b0;
      n_restart++;
    end else begin
      // Spread: column by column, copy each pixel one row up with a random drift.
      for (int x = 0; x < FRAME_WIDTH; x++) begin
        for (int y = 1; y < FRAME_HEIGHT; y++) begin
          src = y * FRAME_WIDTH + x;
          p   = shadow_heat[src];
          if (p == 0) begin
            shadow_heat[src - FRAME_WIDTH] = '0;
          end else begin
            r   = lfsr_draw() & 32'd3;
            dst = (src + FRAME_SIZE + 1 - int'(r) - FRAME_WIDTH) % FRAME_SIZE;
            shadow_heat[dst] = p - r[0];
          end
        end
      end
      if (shadow_delay != DELAY_TARGET) begin
        shadow_delay = shadow_delay - DELAY_STEP;
      end else begin
        // Cool the bottom rows, lowest first, then look for an empty frame.
        n_cooling++;
        for (int k = 0; k < COOL_ROWS; k++) begin
          for (int x = 0; x < FRAME_WIDTH; x++) begin
            pos = (FRAME_HEIGHT - 1 - k) * FRAME_WIDTH + x;
            if (shadow_heat[pos] != 0) begin
              r = lfsr_draw();
              shadow_heat[pos] = shadow_heat[pos] - r[0];
            end
          end
        end
        empty = 1'b1;
        for (int i = 0; i < FRAME_SIZE; i++)
          if (shadow_heat[i] != 0) empty = 1'b0;
        shadow_restart = empty;
      end
    end
    res.restart_pending = shadow_restart;
    res.cooling_active  = (shadow_delay == DELAY_TARGET);
    return res;
  endfunction

  // Mostly in-frame addresses, weighted towards the cooled rows, some beyond the frame.
  function automatic logic [PIX_ADDR_W-1:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return PIX_ADDR_W'($urandom_range(FRAME_SIZE, ADDR_TOP));
    if (roll < 5) return PIX_ADDR_W'($urandom_range(COOL_BASE, FRAME_SIZE - 1));
    return PIX_ADDR_W'($urandom_range(0, FRAME_SIZE - 1));
  endfunction

  // Offer one transaction after a random gap and record its expected status on
  // acceptance. Valid is left high so that a back-to-back item needs no toggle.
  task automatic offer_item(action_e act, logic [PIX_ADDR_W-1:0] addr);
    int gap;
    if ($urandom_range(0, 11) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    pixel_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    pending_status.push_back(burn_step(act, addr));
    if (act == ACT_READ) n_read++;
    else n_advance++;
  endtask

  task automatic offer_random_advance();
    offer_item(ACT_ADVANCE, PIX_ADDR_W'($urandom));
  endtask

  // Drop valid and hold until every owed result has arrived, then let the engine go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  // One register write; callers settle first so nothing is in flight.
  task automatic write_register(cfg_reg_e idx, logic [SEED_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_START_DELAY) begin
      shadow_start_delay = data[DELAY_W-1:0];
    end else begin
      // A zero seed loads as one.
      shadow_lfsr = (data == '0) ? SEED_W'(1) : data;
    end
  endtask

  // Reads of the freshly cleared frame: corners, row edges, beyond the frame,
  // alternating address bits.
  task automatic test_power_up_frame();
    logic [PIX_ADDR_W-1:0] probes [9];
    probes = '{'0, PIX_ADDR_W'(LAST_COL), 12'h555, 12'hAAA,
               PIX_ADDR_W'(LAST_ROW_BASE - 1), PIX_ADDR_W'(LAST_ROW_BASE),
               PIX_ADDR_W'(LAST_ADDR), PIX_ADDR_W'(FRAME_SIZE), PIX_ADDR_W'(ADDR_TOP)};
    foreach (probes[i]) offer_item(ACT_READ, probes[i]);
    settle();
  endtask

  // Both registers at their extremes, the zero seed among them, with a few
  // advances to show the seed taking hold.
  task automatic test_register_extremes();
    write_register(CFG_START_DELAY, SEED_W'(255));
    write_register(CFG_START_DELAY, '0);
    write_register(CFG_RANDOM_SEED, '0);
    offer_random_advance();
    offer_item(ACT_READ, PIX_ADDR_W'(LAST_ROW_BASE - ROW_STEP + 1));
    offer_item(ACT_READ, PIX_ADDR_W'(LAST_ADDR));
    settle();
    write_register(CFG_RANDOM_SEED, '1);
    offer_random_advance();
    offer_random_advance();
    offer_item(ACT_READ, PIX_ADDR_W'(LAST_ROW_BASE - 2 * ROW_STEP + 5));
    offer_item(ACT_READ, PIX_ADDR_W'(10));
    settle();
    write_register(CFG_RANDOM_SEED, SEED_W'($urandom_range(1, 32'hFFFF_FFFF)));
  endtask

  // Hold results off for a long stretch while reads keep coming, so the output
  // register and the core both fill and the input stalls; then pause the sender
  // until the backlog has drained.
  task automatic test_result_backlog();
    sink_hold_request = LONG_HOLD;
    repeat (10) offer_item(ACT_READ, pick_address());
    offer_random_advance();
    offer_item(ACT_READ, pick_address());
    settle();
  endtask

  // Random mix until the delay counter has run down to its target and cooling
  // has begun; reseed between batches.
  task automatic test_delay_countdown();
    int batch;
    batch = 0;
    while (shadow_delay != DELAY_TARGET && n_advance < 400) begin
      if ($urandom_range(0, 99) < 65) offer_random_advance();
      else offer_item(ACT_READ, pick_address());
      if (++batch == SEED_INTERVAL) begin
        batch = 0;
        settle();
        write_register(CFG_RANDOM_SEED, SEED_W'($urandom_range(1, 32'hFFFF_FFFF)));
      end
    end
    repeat (8) begin
      if ($urandom_range(0, 1) == 0) offer_random_advance();
      else offer_item(ACT_READ, pick_address());
    end
    settle();
  endtask

  // Keep cooling until the frame burns out and a restart is flagged, then take
  // the restart advance and watch the short delay lead straight back into cooling.
  task automatic test_burn_out();
    int burned;
    burned = 0;
    write_register(CFG_START_DELAY, SEED_W'(RESTART_DELAY));
    while (!shadow_restart && burned < BURN_CAP) begin
      if ($urandom_range(0, 99) < 80) begin
        offer_random_advance();
        burned++;
      end else begin
        offer_item(ACT_READ, pick_address());
      end
    end
    if (shadow_restart) begin
      offer_random_advance();
      offer_item(ACT_READ, PIX_ADDR_W'(LAST_ADDR));
      offer_item(ACT_READ, PIX_ADDR_W'(LAST_ROW_BASE - 1));
      repeat (4) offer_random_advance();
      repeat (3) offer_item(ACT_READ, pick_address());
    end
    settle();
  endtask

  // Result side: check every accepted result against the oldest expectation and
  // draw a fresh stall length for the next one.
  initial begin : result_sink
    int            hold;
    frame_status_t want;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_status.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding: pixel_value=%0d restart_pending=%0b cooling_active=%0b",
                   $time, pixel_value_o, restart_pending_o, cooling_active_o);
        end else begin
          want = pending_status.pop_front();
          if (pixel_value_o !== want.pixel_value) begin
            errors++;
            $display("%0t: pixel_value expected %0d, got %0d",
                     $time, want.pixel_value, pixel_value_o);
          end
          if (restart_pending_o !== want.restart_pending) begin
            errors++;
            $display("%0t: restart_pending expected %0b, got %0b",
                     $time, want.restart_pending, restart_pending_o);
          end
          if (cooling_active_o !== want.cooling_active) begin
            errors++;
            $display("%0t: cooling_active expected %0b, got %0b",
                     $time, want.cooling_active, cooling_active_o);
          end
        end
        if ($urandom_range(0, 11) == 0) out_burst = !out_burst;
        hold = out_burst ? 0 : $urandom_range(0, 9);
      end
      // A long hold-off asked for by a test replaces the drawn stall.
      if (sink_hold_request > 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stop the run if no transaction moves on any channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("fire_effect_frame_engine_test: done, errors");
    $finish;
  end

  initial begin : run
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_ADVANCE;
    pixel_address_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_START_DELAY;
    cfg_data_i      <= '0;
    // Shadow state as the engine comes out of reset.
    shadow_start_delay = START_DELAY_RESET;
    shadow_lfsr        = SEED_RESET;
    shadow_restart     = 1'b0;
    refill_frame();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_power_up_frame();
    test_register_extremes();
    test_result_backlog();
    test_delay_countdown();
    test_burn_out();

    settle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d advances (%0d cooling, %0d restarts) and %0d pixel reads,",
             n_advance, n_cooling, n_restart, n_read);
    $display("with both registers at their extremes and %0d mismatches.", errors);
    if (errors == 0)
      $display("fire_effect_frame_engine_test: done, clean");
    else
      $display("fire_effect_frame_engine_test: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fe_pkg.sv
design/fe_lfsr.sv
design/fe_core.sv
design/fire_effect_frame_engine.sv
dv/fire_effect_frame_engine_test.sv
